[sv/gpf_pkg.sv]
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared types and constants for the Goldbach partition finder: status codes
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gpf_pkg;

  localparam int NUMBER_WIDTH = 16;
  localparam int FIRST_PRIME  = 2;
  localparam int MIN_EVEN     = 4;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_BAD_INPUT = 2'd1,
    ST_NONE      = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    prime_init;
    logic    sel_high;
    logic    mod_init;
    logic    mod_step;
    logic    next_div;
    logic    next_p;
    logic    out_load;
    status_t out_code;
  } gpf_cmd_t;

  typedef struct packed {
    logic n_bad;
    logic p_over;
    logic x_lt2;
    logic sq_gt_x;
    logic mod_last;
    logic rem_zero;
    logic out_free;
  } gpf_stat_t;

endpackage

[sv/gpf_datapath.sv]
// ----------------------------------------------------------------------------
// gpf_datapath
// Number, candidate and divisor registers, a bit-serial remainder unit and
// the result register that drives the output beat.
// ----------------------------------------------------------------------------
module gpf_datapath #(
  parameter int NUMBER_WIDTH = gpf_pkg::NUMBER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [NUMBER_WIDTH-1:0] even_number,
  input  gpf_pkg::gpf_cmd_t     cmd,
  output gpf_pkg::gpf_stat_t    stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUMBER_WIDTH-1:0] prime_low,
  output logic [NUMBER_WIDTH-1:0] prime_high,
  output logic [1:0]            status
);
  import gpf_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]  n;
  logic [W-1:0]  p;
  logic [W-1:0]  q;
  logic [W-1:0]  x;
  logic [W-1:0]  d;
  logic [W:0]    sq;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvd;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_shift;
  logic          rem_ge;

  assign q         = n - p;
  assign rem_shift = {rem, dvd[W-1]};
  assign rem_ge    = rem_shift >= {1'b0, d};

  assign stat.n_bad    = (n < W'(MIN_EVEN)) || n[0];
  assign stat.p_over   = p > (n >> 1);
  assign stat.x_lt2    = x < W'(FIRST_PRIME);
  assign stat.sq_gt_x  = sq > {1'b0, x};
  assign stat.mod_last = cnt == CW'(W - 1);
  assign stat.rem_zero = rem == '0;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= even_number;
      p <= W'(FIRST_PRIME);
    end else if (cmd.next_p) begin
      p <= p + W'(1);
    end
    if (cmd.prime_init) begin
      x  <= cmd.sel_high ? q : p;
      d  <= W'(FIRST_PRIME);
      sq <= (W+1)'(FIRST_PRIME * FIRST_PRIME);
    end else if (cmd.next_div) begin
      d  <= d + W'(1);
      sq <= sq + {d, 1'b1};
    end
    if (cmd.mod_init) begin
      rem <= '0;
      dvd <= x;
      cnt <= '0;
    end else if (cmd.mod_step) begin
      rem <= rem_ge ? W'(rem_shift - {1'b0, d}) : W'(rem_shift);
      dvd <= dvd << 1;
      cnt <= cnt + CW'(1);
    end
    if (cmd.out_load) begin
      prime_low  <= (cmd.out_code == ST_FOUND) ? p : '0;
      prime_high <= (cmd.out_code == ST_FOUND) ? q : '0;
      status     <= cmd.out_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[sv/gpf_ctrl.sv]
// ----------------------------------------------------------------------------
// gpf_ctrl
// Sequencer: checks the input, walks p upward, runs trial division on p and
// n - p through the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module gpf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gpf_pkg::gpf_stat_t  stat,
  output gpf_pkg::gpf_cmd_t   cmd
);
  import gpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VALIDATE,
    S_PAIR,
    S_PRIME_LOOP,
    S_MOD_RUN,
    S_MOD_CHECK,
    S_RESULT
  } state_t;

  state_t  state;
  state_t  state_next;
  logic    testing_high;
  logic    testing_high_next;
  status_t code;
  status_t code_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next        = state;
    testing_high_next = testing_high;
    code_next         = code;
    cmd               = '0;
    cmd.out_code      = code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_VALIDATE;
        end
      end
      S_VALIDATE: begin
        if (stat.n_bad) begin
          code_next  = ST_BAD_INPUT;
          state_next = S_RESULT;
        end else begin
          state_next = S_PAIR;
        end
      end
      S_PAIR: begin
        if (stat.p_over) begin
          code_next  = ST_NONE;
          state_next = S_RESULT;
        end else begin
          cmd.prime_init    = 1'b1;
          testing_high_next = 1'b0;
          state_next        = S_PRIME_LOOP;
        end
      end
      S_PRIME_LOOP: begin
        if (stat.x_lt2) begin
          cmd.next_p = 1'b1;
          state_next = S_PAIR;
        end else if (stat.sq_gt_x) begin
          if (testing_high) begin
            code_next  = ST_FOUND;
            state_next = S_RESULT;
          end else begin
            cmd.prime_init    = 1'b1;
            cmd.sel_high      = 1'b1;
            testing_high_next = 1'b1;
          end
        end else begin
          cmd.mod_init = 1'b1;
          state_next   = S_MOD_RUN;
        end
      end
      S_MOD_RUN: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_MOD_CHECK;
        end
      end
      S_MOD_CHECK: begin
        if (stat.rem_zero) begin
          cmd.next_p = 1'b1;
          state_next = S_PAIR;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = S_PRIME_LOOP;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      testing_high <= 1'b0;
      code         <= ST_FOUND;
    end else begin
      state        <= state_next;
      testing_high <= testing_high_next;
      code         <= code_next;
    end
  end

endmodule

[sv/goldbach_partition_finder.sv]
// ----------------------------------------------------------------------------
// goldbach_partition_finder
// Splits an even number n into n = p + q with p the smallest prime whose
// complement q is also prime; odd inputs or inputs below 4 give a bad-input
// status, and a missing partition gives a none-found status.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Items are handled one at a time: an input
// is taken only while the sequencer is idle, though a finished result may
// still wait in the output register. For every p tried, the sequencer tests
// p and then n - p by trial division; each remainder comes from a
// bit-serial unit that retires one dividend bit per cycle. Divisors run
// from 2 while d*d stays within the candidate, and a composite candidate
// stops at its first factor. The final test of a prime q needs about
// sqrt(q) divisors. While an earlier result still waits in the output
// register, the sequencer holds at its result step.
// ----------------------------------------------------------------------------
module goldbach_partition_finder #(
  parameter int NUMBER_WIDTH = gpf_pkg::NUMBER_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     s_tdata,  // even_number
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((2*NUMBER_WIDTH+9)/8)*8-1:0]   m_tdata   // prime_low, prime_high, status
);
  import gpf_pkg::*;

  localparam int W     = NUMBER_WIDTH;
  localparam int OUT_W = ((2*W+9)/8)*8;

  gpf_cmd_t   cmd;
  gpf_stat_t  stat;
  logic [W-1:0] prime_low;
  logic [W-1:0] prime_high;
  logic [1:0]   status;

  gpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gpf_datapath #(
    .NUMBER_WIDTH (W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .even_number (s_tdata[W-1:0]),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .prime_low   (prime_low),
    .prime_high  (prime_high),
    .status      (status)
  );

  assign m_tdata = OUT_W'({status, prime_high, prime_low});

endmodule
